@@ design/psrs_pkg.sv @@
// shared types and constants for the page size range splitter
// no dependencies; used by every module of the block by scoped name
`default_nettype none

package psrs_pkg;

   localparam int ADDR_BITS  = 46;
   localparam int PAGE_OFS_W = 12;
   localparam int PFN_W      = ADDR_BITS - PAGE_OFS_W;
   localparam int EXT_W      = PFN_W + 1;
   localparam int MID_SH     = 9;
   localparam int BIG_SH     = 18;
   localparam int MASK_W     = 2;

   localparam logic [EXT_W-1:0] MID_MASK = EXT_W'((64'd1 << MID_SH) - 64'd1);
   localparam logic [EXT_W-1:0] BIG_MASK = EXT_W'((64'd1 << BIG_SH) - 64'd1);

   // segment sequencer codes
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] SEG_HEAD     = 3'd0;
   localparam logic [STEP_W-1:0] SEG_MID      = 3'd1;
   localparam logic [STEP_W-1:0] SEG_BIG      = 3'd2;
   localparam logic [STEP_W-1:0] SEG_MID_TAIL = 3'd3;
   localparam logic [STEP_W-1:0] SEG_TAIL     = 3'd4;

   // register indexes
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_LARGE_PAGE_EN = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GIGA_PAGE_EN  = 1'd1;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic large_en;
      logic giga_en;
   } cfg_type;

   typedef struct packed {
      logic [PFN_W-1:0]  first_pfn;
      logic [PFN_W-1:0]  stop_pfn;
      logic [MASK_W-1:0] mask;
      logic              empty;
      logic              last;
   } piece_type;

endpackage

`default_nettype wire

@@ design/psrs_front.sv @@
// front sequencer: takes a range, walks the five segments one per cycle unless a push stalls, merges neighbours
// depends on psrs_pkg
`default_nettype none

module psrs_front (
   input  logic                         clock,
   input  logic                         reset,
   input  psrs_pkg::cfg_type            cfg,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [psrs_pkg::ADDR_BITS-1:0] in_base,
   input  logic [psrs_pkg::ADDR_BITS-1:0] in_limit,
   output logic                         push_valid,
   input  logic                         push_ready,
   output psrs_pkg::piece_type          push_data
);

   logic                          busy_ff, busy_in;
   logic [psrs_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [psrs_pkg::PFN_W-1:0]    cur_ff, cur_in;
   logic [psrs_pkg::PFN_W-1:0]    hi_ff, hi_in;
   logic                          pend_vld_ff, pend_vld_in;
   psrs_pkg::piece_type           pend_ff, pend_in;
   logic                          owe_ff, owe_in;

   logic [psrs_pkg::EXT_W-1:0]    cur_x, hi_x, up_mid, up_big, dn_mid, dn_big;
   logic [psrs_pkg::EXT_W-1:0]    seg_a, seg_b;
   logic [psrs_pkg::MASK_W-1:0]   seg_mask, m2, m1;
   logic                          has, at_head, merge, advance, accept;
   psrs_pkg::piece_type           new_piece, flush_piece;

   always_comb begin
      cur_x  = {1'b0, cur_ff};
      hi_x   = {1'b0, hi_ff};
      up_mid = (cur_x + psrs_pkg::MID_MASK) & ~psrs_pkg::MID_MASK;
      up_big = (cur_x + psrs_pkg::BIG_MASK) & ~psrs_pkg::BIG_MASK;
      dn_mid = hi_x & ~psrs_pkg::MID_MASK;
      dn_big = hi_x & ~psrs_pkg::BIG_MASK;
      m2     = {1'b0, cfg.large_en};
      m1     = {cfg.giga_en, cfg.large_en};

      unique case (step_ff)
         psrs_pkg::SEG_HEAD: begin
            seg_a    = cur_x;
            seg_b    = (up_mid < hi_x) ? up_mid : hi_x;
            seg_mask = '0;
         end
         psrs_pkg::SEG_MID: begin
            seg_a    = up_mid;
            seg_b    = (up_big < dn_mid) ? up_big : dn_mid;
            seg_mask = m2;
         end
         psrs_pkg::SEG_BIG: begin
            seg_a    = up_big;
            seg_b    = dn_big;
            seg_mask = m1;
         end
         psrs_pkg::SEG_MID_TAIL: begin
            seg_a    = up_mid;
            seg_b    = dn_mid;
            seg_mask = m2;
         end
         psrs_pkg::SEG_TAIL: begin
            seg_a    = cur_x;
            seg_b    = hi_x;
            seg_mask = '0;
         end
         default: begin
            seg_a    = cur_x;
            seg_b    = cur_x;
            seg_mask = '0;
         end
      endcase

      has     = busy_ff && (seg_a < seg_b);
      at_head = busy_ff && (step_ff == psrs_pkg::SEG_HEAD);
      merge   = has && !at_head && pend_vld_ff
                && ({1'b0, pend_ff.stop_pfn} == seg_a) && (pend_ff.mask == seg_mask);

      new_piece.first_pfn = seg_a[psrs_pkg::PFN_W-1:0];
      new_piece.stop_pfn  = seg_b[psrs_pkg::PFN_W-1:0];
      new_piece.mask      = seg_mask;
      new_piece.empty     = 1'b0;
      new_piece.last      = 1'b0;

      // final transfer of the previous range, or the empty marker
      flush_piece.first_pfn = pend_vld_ff ? pend_ff.first_pfn : '0;
      flush_piece.stop_pfn  = pend_vld_ff ? pend_ff.stop_pfn : '0;
      flush_piece.mask      = pend_vld_ff ? pend_ff.mask : '0;
      flush_piece.empty     = !pend_vld_ff;
      flush_piece.last      = 1'b1;

      push_valid = owe_ff || (busy_ff && !at_head && has && !merge && pend_vld_ff);
      if (owe_ff) begin
         push_data = flush_piece;
      end else begin
         push_data      = pend_ff;
         push_data.last = 1'b0;
         push_data.empty = 1'b0;
      end

      advance  = !push_valid || push_ready;
      in_ready = !busy_ff || ((step_ff == psrs_pkg::SEG_TAIL) && advance);
      accept   = in_valid && in_ready;

      busy_in     = busy_ff;
      step_in     = step_ff;
      cur_in      = cur_ff;
      hi_in       = hi_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      owe_in      = owe_ff;

      if (push_valid && push_ready && owe_ff) begin
         owe_in = 1'b0;
      end

      if (busy_ff && advance) begin
         if (has) begin
            cur_in = seg_b[psrs_pkg::PFN_W-1:0];
         end
         if (at_head) begin
            pend_vld_in = has;
            pend_in     = new_piece;
         end else if (merge) begin
            pend_in.stop_pfn = seg_b[psrs_pkg::PFN_W-1:0];
         end else if (has) begin
            pend_vld_in = 1'b1;
            pend_in     = new_piece;
         end
         if (step_ff == psrs_pkg::SEG_TAIL) begin
            busy_in = 1'b0;
            owe_in  = 1'b1;
         end else begin
            step_in = step_ff + 3'd1;
         end
      end

      if (accept) begin
         busy_in = 1'b1;
         step_in = psrs_pkg::SEG_HEAD;
         cur_in  = in_base[psrs_pkg::ADDR_BITS-1:psrs_pkg::PAGE_OFS_W];
         hi_in   = in_limit[psrs_pkg::ADDR_BITS-1:psrs_pkg::PAGE_OFS_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         step_ff     <= psrs_pkg::SEG_HEAD;
         pend_vld_ff <= 1'b0;
         owe_ff      <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         step_ff     <= step_in;
         pend_vld_ff <= pend_vld_in;
         owe_ff      <= owe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      hi_ff   <= hi_in;
      pend_ff <= pend_in;
   end

endmodule

`default_nettype wire

@@ design/psrs_queue.sv @@
// short piece queue between the front sequencer and the output stage
// depends on psrs_pkg
`default_nettype none

module psrs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  psrs_pkg::piece_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output psrs_pkg::piece_type pop_data
);

   psrs_pkg::piece_type          mem [psrs_pkg::QUEUE_DEPTH];
   logic [psrs_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [psrs_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [psrs_pkg::QCNT_W-1:0]  count_ff, count_in;
   logic                         do_push, do_pop;

   always_comb begin
      push_ready = (count_ff != psrs_pkg::QCNT_W'(psrs_pkg::QUEUE_DEPTH));
      pop_valid  = (count_ff != '0);
      pop_data   = mem[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;
      wr_ptr_in  = do_push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in   = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 3'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ design/psrs_back.sv @@
// output stage: takes pieces from the queue and holds each in a result register
// depends on psrs_pkg
`default_nettype none

module psrs_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  psrs_pkg::piece_type            pop_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [psrs_pkg::ADDR_BITS-1:0] rsp_piece_start,
   output logic [psrs_pkg::ADDR_BITS-1:0] rsp_piece_end,
   output logic [psrs_pkg::MASK_W-1:0]    rsp_size_mask,
   output logic                           rsp_empty_res,
   output logic                           rsp_last
);

   logic                           valid_ff, valid_in;
   logic [psrs_pkg::ADDR_BITS-1:0] start_ff, start_in;
   logic [psrs_pkg::ADDR_BITS-1:0] stop_ff, stop_in;
   logic [psrs_pkg::MASK_W-1:0]    mask_ff, mask_in;
   logic                           empty_ff, empty_in;
   logic                           last_ff, last_in;
   logic                           take;

   always_comb begin
      pop_ready = !valid_ff || rsp_ready;
      take      = pop_valid && pop_ready;
      valid_in  = take ? 1'b1 : (valid_ff && !rsp_ready);
      start_in  = start_ff;
      stop_in   = stop_ff;
      mask_in   = mask_ff;
      empty_in  = empty_ff;
      last_in   = last_ff;
      if (take) begin
         start_in = {pop_data.first_pfn, {psrs_pkg::PAGE_OFS_W{1'b0}}};
         stop_in  = {pop_data.stop_pfn, {psrs_pkg::PAGE_OFS_W{1'b0}}};
         mask_in  = pop_data.mask;
         empty_in = pop_data.empty;
         last_in  = pop_data.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      stop_ff  <= stop_in;
      mask_ff  <= mask_in;
      empty_ff <= empty_in;
      last_ff  <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_piece_start = start_ff;
   assign rsp_piece_end   = stop_ff;
   assign rsp_size_mask   = mask_ff;
   assign rsp_empty_res   = empty_ff;
   assign rsp_last        = last_ff;

endmodule

`default_nettype wire

@@ design/page_size_range_splitter.sv @@
// page size range splitter: top level with the two enable registers
// depends on psrs_pkg, psrs_front, psrs_queue and psrs_back
//
// usage
//   req_ channel: one address range [range_base, range_limit) per transfer,
//   both ends truncated to 4K pages.
//   rsp_ channel: one transfer per piece, in ascending order, rsp_last on the
//   final piece; a range with no pages gives one transfer with rsp_empty_res.
//   csr_ port: index 0 large page enable (reset 1), index 1 giga page
//   enable (reset 0); bit 0 of the data is kept. write only while idle.
// timing
//   the front sequencer walks one segment per cycle when the result side
//   keeps up, and takes a new range while on the last segment of the one before.
//   each piece waits in the sequencer until it can no longer merge, then
//   passes through the queue into the result register.
// reset and stalls
//   reset clears the sequencer, the queue and the result register and
//   restores the enables. a stalled result side fills the four-entry queue
//   and then holds the sequencer when it must push; a busy sequencer then holds req_ready low.
`default_nettype none

module page_size_range_splitter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [psrs_pkg::ADDR_BITS-1:0]        req_range_base,
   input  logic [psrs_pkg::ADDR_BITS-1:0]        req_range_limit,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [psrs_pkg::ADDR_BITS-1:0]        rsp_piece_start,
   output logic [psrs_pkg::ADDR_BITS-1:0]        rsp_piece_end,
   output logic [psrs_pkg::MASK_W-1:0]           rsp_size_mask,
   output logic                                  rsp_empty_res,
   output logic                                  rsp_last,
   input  logic                                  csr_wr_en,
   input  logic [psrs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [psrs_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   logic                large_en_ff, large_en_in;
   logic                giga_en_ff, giga_en_in;
   psrs_pkg::cfg_type   cfg;
   logic                push_valid, push_ready, pop_valid, pop_ready;
   psrs_pkg::piece_type push_data, pop_data;

   always_comb begin
      large_en_in = large_en_ff;
      giga_en_in  = giga_en_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            psrs_pkg::CSR_LARGE_PAGE_EN: large_en_in = csr_wdata[0];
            psrs_pkg::CSR_GIGA_PAGE_EN:  giga_en_in  = csr_wdata[0];
            default: begin
            end
         endcase
      end
      cfg.large_en = large_en_ff;
      cfg.giga_en  = giga_en_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         large_en_ff <= 1'b1;
         giga_en_ff  <= 1'b0;
      end else begin
         large_en_ff <= large_en_in;
         giga_en_ff  <= giga_en_in;
      end
   end

   psrs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_base    (req_range_base),
      .in_limit   (req_range_limit),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   psrs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   psrs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_piece_start (rsp_piece_start),
      .rsp_piece_end   (rsp_piece_end),
      .rsp_size_mask   (rsp_size_mask),
      .rsp_empty_res   (rsp_empty_res),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

@@ design/psrs_checker.sv @@
// port level checks on the result channel of the splitter, bound to the top level
// depends on psrs_pkg and page_size_range_splitter
`default_nettype none

module psrs_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [psrs_pkg::ADDR_BITS-1:0] rsp_piece_start,
   input  logic [psrs_pkg::ADDR_BITS-1:0] rsp_piece_end,
   input  logic [psrs_pkg::MASK_W-1:0]    rsp_size_mask,
   input  logic                           rsp_empty_res,
   input  logic                           rsp_last
);

   // nothing offered straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_piece_start)
         && $stable(rsp_piece_end) && $stable(rsp_last))
      else $error("stalled result changed");

   // empty marker is a final all-zero transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_last && (rsp_piece_start == '0)
         && (rsp_piece_end == '0) && (rsp_size_mask == '0))
      else $error("malformed empty result");

   // every real piece has length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_empty_res |-> rsp_piece_start < rsp_piece_end)
      else $error("piece without length");

endmodule

bind page_size_range_splitter psrs_checker u_psrs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_piece_start (rsp_piece_start),
   .rsp_piece_end   (rsp_piece_end),
   .rsp_size_mask   (rsp_size_mask),
   .rsp_empty_res   (rsp_empty_res),
   .rsp_last        (rsp_last)
);

`default_nettype wire
